[rtl/core/spf_pkg.sv]
// shared types, command codes and constants for the stateful packet filter
package spf_pkg;

  localparam int RULE_SLOTS_DEF = 256;
  localparam int FLOW_SLOTS_DEF = 4096;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [15:0] MIN_PACKET_LEN = 16'd20;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // command codes
  localparam logic [2:0] CMD_CHECK  = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_UNLINK = 3'd2;
  localparam logic [2:0] CMD_FLUSH  = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;
  localparam logic [2:0] CMD_PURGE  = 3'd5;

  // decision source codes
  localparam logic [2:0] DEC_DISABLED = 3'd0;
  localparam logic [2:0] DEC_NONE     = 3'd1;
  localparam logic [2:0] DEC_FLOW     = 3'd2;
  localparam logic [2:0] DEC_RULE     = 3'd3;
  localparam logic [2:0] DEC_DEFAULT  = 3'd4;

  // configuration register indexes
  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_DEFAULT = 1'b1;

  // classified request between front and back
  typedef struct packed {
    logic [2:0]  cmd;
    logic        pre;
    logic        pre_verdict;
    logic [2:0]  pre_dec;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] src_ip_mask;
    logic [31:0] dst_ip_mask;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        rule_verdict;
    logic [31:0] argument;
  } req_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] src_ip_mask;
    logic [31:0] dst;
    logic [31:0] dst_ip_mask;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic        action;
  } rule_entry_t;

  typedef struct packed {
    logic        active;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [31:0] seen;
  } flow_entry_t;

endpackage

[rtl/core/spf_ram.sv]
// generic simple dual-port ram with registered read
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/spf_front.sv]
// front end: accepts requests, classifies packets and queues them for the back end
module spf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              busy,
  input  logic              filter_enabled,
  input  logic              default_verdict,
  input  logic [2:0]        cmd,
  input  logic [31:0]       src_ip,
  input  logic [31:0]       dst_ip,
  input  logic [31:0]       src_ip_mask,
  input  logic [31:0]       dst_ip_mask,
  input  logic [7:0]        protocol,
  input  logic [15:0]       sport,
  input  logic [15:0]       dport,
  input  logic              rule_verdict,
  input  logic [15:0]       packet_len,
  input  logic [3:0]        header_words,
  input  logic [31:0]       argument,
  output logic              q_valid,
  output spf_pkg::req_t     q_req,
  input  logic              q_pop
);

  localparam int QD  = spf_pkg::QUEUE_DEPTH;
  localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNW = $clog2(QD + 1);

  spf_pkg::req_t req;
  spf_pkg::req_t queue [QD];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNW-1:0] count;
  logic           take;
  logic           ports_ok;
  logic [15:0]    hdr_need;

  // transport ports count only when the header plus 4 bytes is present
  assign hdr_need = 16'({header_words, 2'b00}) + 16'd4;
  assign ports_ok = ((protocol == spf_pkg::PROTO_TCP) || (protocol == spf_pkg::PROTO_UDP))
                    && (packet_len >= hdr_need);

  // classify the request
  always_comb begin
    req              = '0;
    req.cmd          = cmd;
    req.src_ip       = src_ip;
    req.dst_ip       = dst_ip;
    req.src_ip_mask  = src_ip_mask;
    req.dst_ip_mask  = dst_ip_mask;
    req.protocol     = protocol;
    req.rule_verdict = rule_verdict;
    req.argument     = argument;
    req.sport        = sport;
    req.dport        = dport;
    req.pre_dec      = spf_pkg::DEC_NONE;
    if (cmd == spf_pkg::CMD_CHECK) begin
      if (!ports_ok) begin
        req.sport = '0;
        req.dport = '0;
      end
      if (!filter_enabled) begin
        req.pre         = 1'b1;
        req.pre_verdict = 1'b1;
        req.pre_dec     = spf_pkg::DEC_DISABLED;
      end else if (packet_len < spf_pkg::MIN_PACKET_LEN) begin
        req.pre         = 1'b1;
        req.pre_verdict = default_verdict;
        req.pre_dec     = spf_pkg::DEC_NONE;
      end
    end
  end

  assign full    = (count == CNW'(QD)) || busy;
  assign take    = push && !full;
  assign q_valid = (count != '0);
  assign q_req   = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (take) begin
      queue[wr_ptr] <= req;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (take && !q_pop) begin
        count <= count + 1'b1;
      end else if (!take && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/spf_back.sv]
// back end: flow scan, rule scan, rule table updates and purge, plus the result register
module spf_back #(
  parameter int RULE_SLOTS = spf_pkg::RULE_SLOTS_DEF,
  parameter int FLOW_SLOTS = spf_pkg::FLOW_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          default_verdict,
  input  logic          q_valid,
  input  spf_pkg::req_t q_req,
  output logic          q_pop,
  output logic          busy,
  output logic          empty,
  input  logic          pop,
  output logic          verdict,
  output logic [2:0]    decided_by,
  output logic [7:0]    matched_rule,
  output logic          status,
  output logic [8:0]    rules_used
);

  localparam int RW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int UW  = $clog2(RULE_SLOTS + 1);
  localparam int FW  = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int FCW = $clog2(FLOW_SLOTS + 1);
  localparam int CW  = (FCW > UW) ? FCW : UW;
  localparam int RBW = $bits(spf_pkg::rule_entry_t);
  localparam int FBW = $bits(spf_pkg::flow_entry_t);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FSCAN = 3'd2;
  localparam logic [2:0] S_FHIT  = 3'd3;
  localparam logic [2:0] S_RSCAN = 3'd4;
  localparam logic [2:0] S_PURGE = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]            state;
  logic [CW-1:0]         cnt;
  logic                  d_vld;
  logic [CW-1:0]         d_idx;
  logic [UW-1:0]         used;
  logic [RULE_SLOTS-1:0] linked;
  logic [31:0]           tick;
  spf_pkg::req_t         cur;
  logic                  free_ok;
  logic [FW-1:0]         free_idx;
  logic [FW-1:0]         hit_idx;
  spf_pkg::flow_entry_t  hit_entry;
  logic                  r_verdict;
  logic [2:0]            r_dec;
  logic [7:0]            r_matched;
  logic                  r_status;
  logic                  out_vld;

  logic                  flow_we;
  logic [FW-1:0]         flow_waddr;
  spf_pkg::flow_entry_t  flow_wdata;
  logic                  flow_re;
  logic [FBW-1:0]        flow_rbits;
  spf_pkg::flow_entry_t  fe;
  logic                  rule_we;
  spf_pkg::rule_entry_t  rule_wdata;
  logic                  rule_re;
  logic [RBW-1:0]        rule_rbits;
  spf_pkg::rule_entry_t  re;

  logic                  f_match;
  logic                  f_hit;
  logic                  f_last;
  logic                  r_match;
  logic                  r_hit;
  logic                  r_last;
  logic                  stale;
  logic                  out_free;

  assign fe = spf_pkg::flow_entry_t'(flow_rbits);
  assign re = spf_pkg::rule_entry_t'(rule_rbits);

  // flow compare in either direction
  assign f_match = (fe.proto == cur.protocol) &&
                   (((fe.src == cur.src_ip) && (fe.dst == cur.dst_ip) &&
                     (fe.sport == cur.sport) && (fe.dport == cur.dport)) ||
                    ((fe.src == cur.dst_ip) && (fe.dst == cur.src_ip) &&
                     (fe.sport == cur.dport) && (fe.dport == cur.sport)));
  assign f_hit  = d_vld && fe.active && f_match;
  assign f_last = d_vld && (d_idx == CW'(FLOW_SLOTS - 1));

  // rule compare with masks and zero wildcards
  assign r_match = ((cur.src_ip & re.src_ip_mask) == (re.src & re.src_ip_mask)) &&
                   ((cur.dst_ip & re.dst_ip_mask) == (re.dst & re.dst_ip_mask)) &&
                   ((re.proto == '0) || (re.proto == cur.protocol)) &&
                   ((re.sport == '0) || (re.sport == cur.sport)) &&
                   ((re.dport == '0) || (re.dport == cur.dport));
  assign r_hit  = d_vld && linked[d_idx[RW-1:0]] && r_match;
  assign r_last = d_vld && (d_idx == (CW'(used) - CW'(1)));

  assign stale    = (tick - fe.seen) > cur.argument;
  assign out_free = !out_vld || pop;
  assign busy     = (state == S_CLR);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign empty    = !out_vld;

  // read issue
  assign flow_re = ((state == S_FSCAN) || (state == S_PURGE)) && (cnt < CW'(FLOW_SLOTS));
  assign rule_re = (state == S_RSCAN) && (cnt < CW'(used));

  // flow table write selection
  always_comb begin
    flow_we    = 1'b0;
    flow_waddr = cnt[FW-1:0];
    flow_wdata = '0;
    case (state)
      S_CLR: begin
        flow_we = 1'b1;
      end
      S_FHIT: begin
        flow_we         = 1'b1;
        flow_waddr      = hit_idx;
        flow_wdata      = hit_entry;
        flow_wdata.seen = tick;
      end
      S_RSCAN: begin
        flow_we           = r_hit && re.action && free_ok;
        flow_waddr        = free_idx;
        flow_wdata.active = 1'b1;
        flow_wdata.src    = cur.src_ip;
        flow_wdata.dst    = cur.dst_ip;
        flow_wdata.sport  = cur.sport;
        flow_wdata.dport  = cur.dport;
        flow_wdata.proto  = cur.protocol;
        flow_wdata.seen   = tick;
      end
      S_PURGE: begin
        flow_we           = d_vld && fe.active && stale;
        flow_waddr        = d_idx[FW-1:0];
        flow_wdata        = fe;
        flow_wdata.active = 1'b0;
      end
      default: begin
        flow_we = 1'b0;
      end
    endcase
  end

  // rule append
  assign rule_we = q_pop && (q_req.cmd == spf_pkg::CMD_ADD) && (used < UW'(RULE_SLOTS));
  always_comb begin
    rule_wdata             = '0;
    rule_wdata.src         = q_req.src_ip;
    rule_wdata.src_ip_mask = q_req.src_ip_mask;
    rule_wdata.dst         = q_req.dst_ip;
    rule_wdata.dst_ip_mask = q_req.dst_ip_mask;
    rule_wdata.sport       = q_req.sport;
    rule_wdata.dport       = q_req.dport;
    rule_wdata.proto       = q_req.protocol;
    rule_wdata.action      = q_req.rule_verdict;
  end

  spf_ram #(.WIDTH(FBW), .DEPTH(FLOW_SLOTS)) u_flow_ram (
    .clk     (clk),
    .wr_en   (flow_we),
    .wr_addr (flow_waddr),
    .wr_data (flow_wdata),
    .rd_en   (flow_re),
    .rd_addr (cnt[FW-1:0]),
    .rd_data (flow_rbits)
  );

  spf_ram #(.WIDTH(RBW), .DEPTH(RULE_SLOTS)) u_rule_ram (
    .clk     (clk),
    .wr_en   (rule_we),
    .wr_addr (used[RW-1:0]),
    .wr_data (rule_wdata),
    .rd_en   (rule_re),
    .rd_addr (cnt[RW-1:0]),
    .rd_data (rule_rbits)
  );

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      cnt     <= '0;
      d_vld   <= 1'b0;
      used    <= '0;
      linked  <= '0;
      tick    <= '0;
      out_vld <= 1'b0;
      free_ok <= 1'b0;
    end else begin
      d_vld <= flow_re || rule_re;
      d_idx <= cnt;
      if (flow_re || rule_re) begin
        cnt <= cnt + 1'b1;
      end
      if (pop && out_vld) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(FLOW_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt       <= '0;
          d_vld     <= 1'b0;
          free_ok   <= 1'b0;
          r_verdict <= 1'b0;
          r_dec     <= spf_pkg::DEC_NONE;
          r_matched <= '0;
          r_status  <= 1'b0;
          if (q_valid) begin
            cur   <= q_req;
            state <= S_OUT;
            case (q_req.cmd)
              spf_pkg::CMD_CHECK: begin
                if (q_req.pre) begin
                  r_verdict <= q_req.pre_verdict;
                  r_dec     <= q_req.pre_dec;
                end else begin
                  state <= S_FSCAN;
                end
              end
              spf_pkg::CMD_ADD: begin
                if (used >= UW'(RULE_SLOTS)) begin
                  r_status <= 1'b1;
                end else begin
                  linked[used[RW-1:0]] <= 1'b1;
                  used                 <= used + 1'b1;
                end
              end
              spf_pkg::CMD_UNLINK: begin
                if (q_req.argument >= 32'(used)) begin
                  r_status <= 1'b1;
                end else begin
                  linked[q_req.argument[RW-1:0]] <= 1'b0;
                end
              end
              spf_pkg::CMD_FLUSH: begin
                linked <= '0;
                used   <= '0;
              end
              spf_pkg::CMD_TICK: begin
                tick <= tick + 1'b1;
              end
              spf_pkg::CMD_PURGE: begin
                state <= S_PURGE;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_FSCAN: begin
          if (d_vld && !fe.active && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= d_idx[FW-1:0];
          end
          if (f_hit) begin
            hit_idx   <= d_idx[FW-1:0];
            hit_entry <= fe;
            state     <= S_FHIT;
          end else if (f_last) begin
            cnt   <= '0;
            d_vld <= 1'b0;
            if (used == '0) begin
              r_verdict <= default_verdict;
              r_dec     <= spf_pkg::DEC_DEFAULT;
              state     <= S_OUT;
            end else begin
              state <= S_RSCAN;
            end
          end
        end
        S_FHIT: begin
          r_verdict <= 1'b1;
          r_dec     <= spf_pkg::DEC_FLOW;
          state     <= S_OUT;
        end
        S_RSCAN: begin
          if (r_hit) begin
            r_verdict <= re.action;
            r_dec     <= spf_pkg::DEC_RULE;
            r_matched <= d_idx[7:0];
            state     <= S_OUT;
          end else if (r_last) begin
            r_verdict <= default_verdict;
            r_dec     <= spf_pkg::DEC_DEFAULT;
            state     <= S_OUT;
          end
        end
        S_PURGE: begin
          if (f_last) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            verdict      <= r_verdict;
            decided_by   <= r_dec;
            matched_rule <= r_matched;
            status       <= r_status;
            rules_used   <= 9'(used);
            out_vld      <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/stateful_packet_filter_unit.sv]
// top level of the stateful five-tuple packet filter
//
// Requests enter through a queue-style port: an item is taken at a clock edge
// with push high and full low. Results leave the same way: while empty is low
// the oldest result sits on the result ports and is taken with pop high.
// Two configuration registers (0 filter enable, 1 default verdict) are written
// through cfg_wr_en / cfg_index / cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce this. A two-entry
// request queue feeds the back end, so requests keep being taken while the back
// end is busy or a result waits to be popped. Rule commands, tick and short or
// bypassed packets pass from the back end's idle state straight to its output
// state and then the result register. A full packet check reads the flow table
// one slot per cycle and, on a miss, the rule table one slot per cycle up to the
// first match; a purge reads every flow slot in turn. Each table has a single
// read port. After reset the flow table is cleared one slot per cycle; full
// stays high during that pass. When pop is held low, one result waits in the
// output register, the back end holds the next one, and the queue fills until
// full rises.
module stateful_packet_filter_unit #(
  parameter int RULE_SLOTS = spf_pkg::RULE_SLOTS_DEF,
  parameter int FLOW_SLOTS = spf_pkg::FLOW_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [31:0] src_ip_mask,
  input  logic [31:0] dst_ip_mask,
  input  logic [7:0]  protocol,
  input  logic [15:0] sport,
  input  logic [15:0] dport,
  input  logic        rule_verdict,
  input  logic [15:0] packet_len,
  input  logic [3:0]  header_words,
  input  logic [31:0] argument,
  output logic        empty,
  input  logic        pop,
  output logic        verdict,
  output logic [2:0]  decided_by,
  output logic [7:0]  matched_rule,
  output logic        status,
  output logic [8:0]  rules_used
);

  logic          filter_enabled;
  logic          default_verdict;
  logic          busy;
  logic          q_valid;
  logic          q_pop;
  spf_pkg::req_t q_req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enabled  <= 1'b1;
      default_verdict <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        spf_pkg::CFG_ENABLE:  filter_enabled  <= cfg_data;
        spf_pkg::CFG_DEFAULT: default_verdict <= cfg_data;
        default:              filter_enabled  <= filter_enabled;
      endcase
    end
  end

  spf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .busy            (busy),
    .filter_enabled  (filter_enabled),
    .default_verdict (default_verdict),
    .cmd             (cmd),
    .src_ip          (src_ip),
    .dst_ip          (dst_ip),
    .src_ip_mask     (src_ip_mask),
    .dst_ip_mask     (dst_ip_mask),
    .protocol        (protocol),
    .sport           (sport),
    .dport           (dport),
    .rule_verdict    (rule_verdict),
    .packet_len      (packet_len),
    .header_words    (header_words),
    .argument        (argument),
    .q_valid         (q_valid),
    .q_req           (q_req),
    .q_pop           (q_pop)
  );

  spf_back #(.RULE_SLOTS(RULE_SLOTS), .FLOW_SLOTS(FLOW_SLOTS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .default_verdict (default_verdict),
    .q_valid         (q_valid),
    .q_req           (q_req),
    .q_pop           (q_pop),
    .busy            (busy),
    .empty           (empty),
    .pop             (pop),
    .verdict         (verdict),
    .decided_by      (decided_by),
    .matched_rule    (matched_rule),
    .status          (status),
    .rules_used      (rules_used)
  );

endmodule

[verif/tb_stateful_packet_filter_unit.sv]
// testbench for the stateful packet filter: queued requests, model-based result checking
`timescale 1ns / 1ps

module tb_stateful_packet_filter_unit;

  localparam int RULES = spf_pkg::RULE_SLOTS_DEF;
  localparam int FLOWS = spf_pkg::FLOW_SLOTS_DEF;
  localparam int DRAIN_CYCLES = FLOWS + RULES + 20;
  localparam longint CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] src_ip_mask;
    logic [31:0] dst_ip_mask;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        rule_verdict;
    logic [15:0] packet_len;
    logic [3:0]  header_words;
    logic [31:0] argument;
  } request_t;

  typedef struct packed {
    logic       verdict;
    logic [2:0] decided_by;
    logic [7:0] matched_rule;
    logic       status;
    logic [8:0] rules_used;
  } decision_t;

  logic clk, rst;
  logic cfg_wr_en, cfg_index, cfg_data;
  logic full, empty;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [2:0] cmd = '0;
  logic [31:0] src_ip = '0, dst_ip = '0, src_ip_mask = '0, dst_ip_mask = '0, argument = '0;
  logic [7:0] protocol = '0;
  logic [15:0] sport = '0, dport = '0, packet_len = '0;
  logic rule_verdict = 1'b0;
  logic [3:0] header_words = '0;
  logic verdict, status;
  logic [2:0] decided_by;
  logic [7:0] matched_rule;
  logic [8:0] rules_used;

  stateful_packet_filter_unit u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .cmd(cmd), .src_ip(src_ip), .dst_ip(dst_ip),
    .src_ip_mask(src_ip_mask), .dst_ip_mask(dst_ip_mask), .protocol(protocol), .sport(sport),
    .dport(dport), .rule_verdict(rule_verdict), .packet_len(packet_len),
    .header_words(header_words), .argument(argument), .empty(empty), .pop(pop),
    .verdict(verdict), .decided_by(decided_by), .matched_rule(matched_rule),
    .status(status), .rules_used(rules_used)
  );

  // shadow state of the filter
  logic        cfg_enable, cfg_default;
  logic [31:0] r_src [RULES];
  logic [31:0] r_smask [RULES];
  logic [31:0] r_dst [RULES];
  logic [31:0] r_dmask [RULES];
  logic [15:0] r_sport [RULES];
  logic [15:0] r_dport [RULES];
  logic [7:0]  r_proto [RULES];
  logic        r_action [RULES];
  bit          r_linked [RULES];
  int          rules_in_use = 0;
  logic [31:0] f_src [FLOWS];
  logic [31:0] f_dst [FLOWS];
  logic [15:0] f_sport [FLOWS];
  logic [15:0] f_dport [FLOWS];
  logic [7:0]  f_proto [FLOWS];
  logic [31:0] f_seen [FLOWS];
  bit          f_active [FLOWS];
  logic [31:0] tick_now = '0;

  request_t  pending_q[$];
  decision_t decision_q[$];
  request_t  cur_req;
  int        fail_count = 0;
  longint    cycle_count = 0;
  int        send_gap = 0;
  int        pop_gap = 0;
  logic [31:0] addr_pool [4];
  logic [15:0] port_pool [3];

  // work out the decision for one request and update the shadow state
  function automatic decision_t filter_decide(request_t rq);
    decision_t d;
    int fi, k;
    bit hit;
    logic [15:0] psp, pdp;
    d = '0;
    d.decided_by = spf_pkg::DEC_NONE;
    case (rq.cmd)
      spf_pkg::CMD_CHECK: begin
        if (!cfg_enable) begin
          d.verdict = 1'b1;
          d.decided_by = spf_pkg::DEC_DISABLED;
        end else if (rq.packet_len < spf_pkg::MIN_PACKET_LEN) begin
          d.verdict = cfg_default;
        end else begin
          psp = '0;
          pdp = '0;
          if ((rq.protocol == spf_pkg::PROTO_TCP || rq.protocol == spf_pkg::PROTO_UDP) &&
              int'(rq.packet_len) >= int'(rq.header_words) * 4 + 4) begin
            psp = rq.sport;
            pdp = rq.dport;
          end
          fi = -1;
          for (k = 0; k < FLOWS && fi < 0; k++) begin
            if (f_active[k] && f_proto[k] == rq.protocol &&
                ((f_src[k] == rq.src_ip && f_dst[k] == rq.dst_ip &&
                  f_sport[k] == psp && f_dport[k] == pdp) ||
                 (f_src[k] == rq.dst_ip && f_dst[k] == rq.src_ip &&
                  f_sport[k] == pdp && f_dport[k] == psp)))
              fi = k;
          end
          if (fi >= 0) begin
            f_seen[fi] = tick_now;
            d.verdict = 1'b1;
            d.decided_by = spf_pkg::DEC_FLOW;
          end else begin
            d.verdict = cfg_default;
            d.decided_by = spf_pkg::DEC_DEFAULT;
            hit = 0;
            for (k = 0; k < rules_in_use && !hit; k++) begin
              if (r_linked[k] &&
                  (rq.src_ip & r_smask[k]) == (r_src[k] & r_smask[k]) &&
                  (rq.dst_ip & r_dmask[k]) == (r_dst[k] & r_dmask[k]) &&
                  (r_proto[k] == 0 || r_proto[k] == rq.protocol) &&
                  (r_sport[k] == 0 || r_sport[k] == psp) &&
                  (r_dport[k] == 0 || r_dport[k] == pdp)) begin
                hit = 1;
                d.verdict = r_action[k];
                d.decided_by = spf_pkg::DEC_RULE;
                d.matched_rule = k[7:0];
              end
            end
            // accepted by a rule: track the flow in the first free slot
            if (hit && d.verdict) begin
              fi = -1;
              for (k = 0; k < FLOWS && fi < 0; k++)
                if (!f_active[k]) fi = k;
              if (fi >= 0) begin
                f_src[fi] = rq.src_ip;
                f_dst[fi] = rq.dst_ip;
                f_sport[fi] = psp;
                f_dport[fi] = pdp;
                f_proto[fi] = rq.protocol;
                f_seen[fi] = tick_now;
                f_active[fi] = 1;
              end
            end
          end
        end
      end
      spf_pkg::CMD_ADD: begin
        if (rules_in_use >= RULES) begin
          d.status = 1'b1;
        end else begin
          r_src[rules_in_use] = rq.src_ip;
          r_smask[rules_in_use] = rq.src_ip_mask;
          r_dst[rules_in_use] = rq.dst_ip;
          r_dmask[rules_in_use] = rq.dst_ip_mask;
          r_sport[rules_in_use] = rq.sport;
          r_dport[rules_in_use] = rq.dport;
          r_proto[rules_in_use] = rq.protocol;
          r_action[rules_in_use] = rq.rule_verdict;
          r_linked[rules_in_use] = 1;
          rules_in_use++;
        end
      end
      spf_pkg::CMD_UNLINK: begin
        if (longint'(rq.argument) >= rules_in_use) d.status = 1'b1;
        else r_linked[rq.argument] = 0;
      end
      spf_pkg::CMD_FLUSH: begin
        for (k = 0; k < RULES; k++) r_linked[k] = 0;
        rules_in_use = 0;
      end
      spf_pkg::CMD_TICK: tick_now = tick_now + 32'd1;
      spf_pkg::CMD_PURGE: begin
        for (k = 0; k < FLOWS; k++)
          if (f_active[k] && (tick_now - f_seen[k]) > rq.argument) f_active[k] = 0;
      end
      default: ;
    endcase
    d.rules_used = rules_in_use[8:0];
    return d;
  endfunction

  // request with every field random, then shaped by the callers
  function automatic request_t any_request(logic [2:0] c);
    request_t rq;
    rq = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    rq.cmd = c;
    return rq;
  endfunction

  // well-formed packet drawn from the small address and port pools
  function automatic request_t pool_packet();
    request_t rq;
    int p;
    rq = any_request(spf_pkg::CMD_CHECK);
    rq.src_ip = addr_pool[$urandom_range(0, 3)];
    rq.dst_ip = addr_pool[$urandom_range(0, 3)];
    rq.sport = port_pool[$urandom_range(0, 2)];
    rq.dport = port_pool[$urandom_range(0, 2)];
    p = $urandom_range(0, 9);
    rq.protocol = (p < 4) ? spf_pkg::PROTO_TCP : (p < 8) ? spf_pkg::PROTO_UDP :
                  8'($urandom_range(0, 255));
    p = $urandom_range(0, 9);
    rq.header_words = 4'($urandom_range(0, 15));
    if (p == 0) rq.packet_len = 16'($urandom_range(0, 19));
    else if (p == 1) rq.packet_len = 16'($urandom_range(20, 63));
    else if (p == 2) rq.packet_len = 16'($urandom);
    else rq.packet_len = 16'($urandom_range(64, 1500));
    return rq;
  endfunction

  // well-formed rule over the pools
  function automatic request_t pool_rule();
    request_t rq;
    int p;
    rq = any_request(spf_pkg::CMD_ADD);
    rq.src_ip = addr_pool[$urandom_range(0, 3)];
    rq.dst_ip = addr_pool[$urandom_range(0, 3)];
    p = $urandom_range(0, 3);
    rq.src_ip_mask = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FF00 :
                     (p == 2) ? 32'hFFFF_FFFF : $urandom;
    p = $urandom_range(0, 3);
    rq.dst_ip_mask = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_0000 :
                     (p == 2) ? 32'hFFFF_FFFF : $urandom;
    p = $urandom_range(0, 3);
    rq.protocol = (p == 0) ? 8'd0 : (p == 1) ? spf_pkg::PROTO_TCP :
                  (p == 2) ? spf_pkg::PROTO_UDP : 8'($urandom);
    rq.sport = $urandom_range(0, 1) ? 16'd0 : port_pool[$urandom_range(0, 2)];
    rq.dport = $urandom_range(0, 1) ? 16'd0 : port_pool[$urandom_range(0, 2)];
    rq.rule_verdict = ($urandom_range(0, 3) != 0);
    return rq;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) rq = pool_packet();
    else if (p < 55) rq = any_request(spf_pkg::CMD_CHECK);
    else if (p < 68) rq = pool_rule();
    else if (p < 75) begin
      rq = any_request(spf_pkg::CMD_UNLINK);
      if ($urandom_range(0, 3) != 0) rq.argument = $urandom_range(0, 12);
    end else if (p < 78) rq = any_request(spf_pkg::CMD_FLUSH);
    else if (p < 89) rq = any_request(spf_pkg::CMD_TICK);
    else if (p < 96) begin
      rq = any_request(spf_pkg::CMD_PURGE);
      if ($urandom_range(0, 3) != 0) rq.argument = $urandom_range(0, 6);
    end else rq = any_request(3'($urandom_range(6, 7)));
    return rq;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    fail_count++;
  endtask

  // write one configuration register while the block is idle
  task automatic write_cfg(logic idx, logic val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == spf_pkg::CFG_ENABLE) cfg_enable = val;
    else cfg_default = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // let every queued request be answered
  task automatic settle();
    while (pending_q.size() != 0 || decision_q.size() != 0 || push) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        decision_q.push_back(filter_decide(cur_req));
        void'(pending_q.pop_front());
        send_gap = $urandom_range(0, 19);
        if (send_gap == 0 && pending_q.size() > 0) begin
          cur_req = pending_q[0];
          {cmd, src_ip, dst_ip, src_ip_mask, dst_ip_mask, protocol, sport, dport,
           rule_verdict, packet_len, header_words, argument} <= cur_req;
        end else begin
          push <= 1'b0;
        end
      end else if (!push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q[0];
          {cmd, src_ip, dst_ip, src_ip_mask, dst_ip_mask, protocol, sport, dport,
           rule_verdict, packet_len, header_words, argument} <= cur_req;
          push <= 1'b1;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    decision_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (decision_q.size() == 0) begin
          $display("unexpected result at cycle %0d", cycle_count);
          fail_count++;
        end else begin
          want = decision_q.pop_front();
          if (verdict !== want.verdict) report("verdict", verdict, want.verdict);
          if (decided_by !== want.decided_by) report("decided_by", decided_by, want.decided_by);
          if (matched_rule !== want.matched_rule)
            report("matched_rule", matched_rule, want.matched_rule);
          if (status !== want.status) report("status", status, want.status);
          if (rules_used !== want.rules_used) report("rules_used", rules_used, want.rules_used);
        end
        pop_gap = $urandom_range(0, 19);
        if (pop_gap != 0) pop <= 1'b0;
      end else if (!pop) begin
        if (pop_gap > 0) pop_gap--;
        else pop <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    request_t rq;
    int k;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 1'b0;
    cfg_enable = 1'b1;
    cfg_default = 1'b0;
    for (k = 0; k < 4; k++) addr_pool[k] = $urandom;
    for (k = 0; k < 3; k++) port_pool[k] = 16'($urandom_range(1, 65535));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (!full);
    write_cfg(spf_pkg::CFG_ENABLE, 1'b1);
    write_cfg(spf_pkg::CFG_DEFAULT, 1'b0);

    // directed: rules, flow tracking both ways, short packets, unlink, purge
    rq = any_request(spf_pkg::CMD_CHECK);
    rq.packet_len = 16'd0;
    pending_q.push_back(rq);
    rq.packet_len = 16'd19;
    pending_q.push_back(rq);
    rq = any_request(spf_pkg::CMD_ADD);
    rq.src_ip = addr_pool[0];
    rq.dst_ip = addr_pool[1];
    rq.src_ip_mask = 32'hFFFF_FFFF;
    rq.dst_ip_mask = 32'hFFFF_FF00;
    rq.protocol = spf_pkg::PROTO_TCP;
    rq.sport = 16'd0;
    rq.dport = port_pool[0];
    rq.rule_verdict = 1'b1;
    pending_q.push_back(rq);
    rq = any_request(spf_pkg::CMD_ADD);
    rq.src_ip_mask = 32'h0;
    rq.dst_ip_mask = 32'h0;
    rq.protocol = 8'd0;
    rq.sport = 16'd0;
    rq.dport = 16'd0;
    rq.rule_verdict = 1'b0;
    pending_q.push_back(rq);
    rq = any_request(spf_pkg::CMD_CHECK);
    rq.src_ip = addr_pool[0];
    rq.dst_ip = addr_pool[1];
    rq.protocol = spf_pkg::PROTO_TCP;
    rq.sport = port_pool[1];
    rq.dport = port_pool[0];
    rq.header_words = 4'd5;
    rq.packet_len = 16'd24;
    pending_q.push_back(rq);
    // reverse direction hits the tracked flow
    {rq.src_ip, rq.dst_ip} = {rq.dst_ip, rq.src_ip};
    {rq.sport, rq.dport} = {rq.dport, rq.sport};
    pending_q.push_back(rq);
    // length one short of the ports: ports read as zero
    rq.packet_len = 16'd23;
    pending_q.push_back(rq);
    rq.header_words = 4'hF;
    rq.packet_len = 16'hFFFF;
    rq.protocol = spf_pkg::PROTO_UDP;
    pending_q.push_back(rq);
    rq = any_request(spf_pkg::CMD_TICK);
    pending_q.push_back(rq);
    rq = any_request(spf_pkg::CMD_PURGE);
    rq.argument = 32'hFFFF_FFFF;
    pending_q.push_back(rq);
    rq.argument = 32'd0;
    pending_q.push_back(rq);
    rq = any_request(spf_pkg::CMD_UNLINK);
    rq.argument = 32'd0;
    pending_q.push_back(rq);
    pending_q.push_back(rq);
    rq.argument = 32'd2;
    pending_q.push_back(rq);
    rq.argument = 32'hFFFF_FFFF;
    pending_q.push_back(rq);
    pending_q.push_back(pool_packet());
    pending_q.push_back(any_request(3'd6));
    pending_q.push_back(any_request(3'd7));
    pending_q.push_back(any_request(spf_pkg::CMD_FLUSH));
    pending_q.push_back(any_request(spf_pkg::CMD_CHECK));
    settle();

    // filter off, default accept
    write_cfg(spf_pkg::CFG_ENABLE, 1'b0);
    write_cfg(spf_pkg::CFG_DEFAULT, 1'b1);
    for (k = 0; k < 6; k++) pending_q.push_back(pool_packet());
    settle();

    // random traffic, default drop
    write_cfg(spf_pkg::CFG_ENABLE, 1'b1);
    write_cfg(spf_pkg::CFG_DEFAULT, 1'b0);
    for (k = 0; k < 52; k++) pending_q.push_back(random_request());
    settle();

    // random traffic, default accept
    write_cfg(spf_pkg::CFG_DEFAULT, 1'b1);
    for (k = 0; k < 52; k++) pending_q.push_back(random_request());
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && decision_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
